// ===== rtl/ufr_pkg.sv =====
// Shared types and constants for the UART frame receiver with CRC-16 check.
`timescale 1ns / 1ps

package ufr_pkg;

  localparam int UFR_BUFFER_BYTES_DEFAULT = 32;
  localparam int UFR_QUEUE_DEPTH = 2;
  localparam int MIN_FRAME = 8;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP = 16'h8000;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_IDLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_HEAD_BYTE        = 2'd0,
    CFG_TAIL_FIRST_BYTE  = 2'd1,
    CFG_TAIL_SECOND_BYTE = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    STATUS_VALID           = 3'd0,
    STATUS_TOO_SHORT       = 3'd1,
    STATUS_BAD_FRAME       = 3'd2,
    STATUS_LENGTH_MISMATCH = 3'd3,
    STATUS_CRC_MISMATCH    = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] tail_first_byte;
    logic [7:0] tail_second_byte;
  } frame_cfg_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_item_t;

  typedef struct packed {
    status_t     frame_status;
    logic [7:0]  command;
    logic [15:0] payload_length;
    logic [15:0] frame_crc;
    logic [15:0] computed_crc;
  } result_t;

endpackage

// ===== rtl/ufr_queue.sv =====
// Small first-in first-out queue built from registers.
`timescale 1ns / 1ps

module ufr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ufr_engine.sv =====
// Frame engine: byte capture, CRC-16 update and verdict for each frame.
`timescale 1ns / 1ps

module ufr_engine import ufr_pkg::*; #(
  parameter int BUFFER_BYTES = UFR_BUFFER_BYTES_DEFAULT,
  parameter int CNT_W = $clog2(BUFFER_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  frame_cfg_t       cfg,
  input  logic             cmd_empty,
  input  cmd_item_t        cmd_item,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output result_t          res_item,
  output logic [CNT_W-1:0] frame_count
);

  logic [CNT_W-1:0] byte_count;
  logic [7:0]       first_byte;
  logic [7:0]       command_byte;
  logic [15:0]      length_field;
  logic [15:0]      crc_accumulator;
  logic [7:0]       last_four_bytes [4];

  logic             is_byte;
  logic             take_byte;
  logic             close_frame;
  logic [15:0]      rcrc;
  logic             too_short;
  logic             bad_frame;
  logic             length_bad;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != '0) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  assign is_byte = (cmd_item.op == OP_BYTE);

  // An idle event that closes a frame needs room in the result queue; anything
  // else can always be consumed.
  assign cmd_pop     = !cmd_empty && (is_byte || byte_count == '0 || !res_full);
  assign take_byte   = cmd_pop && is_byte && (byte_count < CNT_W'(BUFFER_BYTES));
  assign close_frame = cmd_pop && !is_byte && (byte_count != '0);
  assign res_push    = close_frame;
  assign frame_count = byte_count;

  assign rcrc       = {last_four_bytes[0], last_four_bytes[1]};
  assign too_short  = (byte_count < CNT_W'(MIN_FRAME));
  assign bad_frame  = (first_byte != cfg.head_byte) ||
                      (last_four_bytes[2] != cfg.tail_first_byte) ||
                      (last_four_bytes[3] != cfg.tail_second_byte);
  assign length_bad = (17'(byte_count) != 17'(MIN_FRAME) + {1'b0, length_field});

  always_comb begin
    res_item.command        = command_byte;
    res_item.payload_length = length_field;
    res_item.frame_crc      = rcrc;
    res_item.computed_crc   = crc_accumulator;
    if (too_short) begin
      res_item.frame_status   = STATUS_TOO_SHORT;
      res_item.command        = '0;
      res_item.payload_length = '0;
      res_item.frame_crc      = '0;
      res_item.computed_crc   = '0;
    end else if (bad_frame) begin
      res_item.frame_status = STATUS_BAD_FRAME;
    end else if (length_bad) begin
      res_item.frame_status = STATUS_LENGTH_MISMATCH;
    end else if (crc_accumulator != rcrc) begin
      res_item.frame_status = STATUS_CRC_MISMATCH;
    end else begin
      res_item.frame_status = STATUS_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || close_frame) begin
      byte_count      <= '0;
      first_byte      <= '0;
      command_byte    <= '0;
      length_field    <= '0;
      crc_accumulator <= '0;
      for (int i = 0; i < 4; i++) begin
        last_four_bytes[i] <= '0;
      end
    end else if (take_byte) begin
      if (byte_count == CNT_W'(0)) begin
        first_byte <= cmd_item.data;
      end
      if (byte_count == CNT_W'(1)) begin
        command_byte <= cmd_item.data;
      end
      if (byte_count == CNT_W'(2)) begin
        length_field <= {cmd_item.data, 8'h00};
      end
      if (byte_count == CNT_W'(3)) begin
        length_field <= {length_field[15:8], cmd_item.data};
      end
      // A byte enters the CRC as it leaves the four-byte window, which keeps
      // the received CRC and the tail out of the sum.
      if (byte_count >= CNT_W'(5)) begin
        crc_accumulator <= crc_feed(crc_accumulator, last_four_bytes[0]);
      end
      last_four_bytes[0] <= last_four_bytes[1];
      last_four_bytes[1] <= last_four_bytes[2];
      last_four_bytes[2] <= last_four_bytes[3];
      last_four_bytes[3] <= cmd_item.data;
      byte_count         <= byte_count + 1'b1;
    end
  end

endmodule

// ===== rtl/uart_frame_receiver_crc16.sv =====
// UART request-frame receiver with CRC-16 check: top level.
//
// Input channel: push with operation and rx_byte; a transfer happens when push is
// high and full is low. Operation 0 carries a received byte, operation 1 marks
// the receive line going idle. Up to BUFFER_BYTES bytes of a frame are taken
// into account; later bytes are dropped until the next idle event.
// Result channel: while empty is low the oldest verdict is on frame_status,
// command, payload_length, frame_crc and computed_crc; pop takes it.
// An idle event with bytes pending gives exactly one verdict; one with no
// bytes gives none. Configuration: cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high and writes should be made while idle.
// Throughput is one item per clock while the result queue has room, set by
// the byte-wide CRC update in the frame engine. A verdict is registered in
// the result queue before it shows on the result ports and can be taken. If the
// result side stalls, the result queue fills, the engine holds the closing
// idle event and the input queue then raises full. Reset clears both queues,
// the frame state and the three configuration registers to zero.
`timescale 1ns / 1ps

module uart_frame_receiver_crc16 import ufr_pkg::*; #(
  parameter int BUFFER_BYTES = UFR_BUFFER_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        operation,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  frame_status,
  output logic [7:0]  command,
  output logic [15:0] payload_length,
  output logic [15:0] frame_crc,
  output logic [15:0] computed_crc,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int CMD_W = $bits(cmd_item_t);
  localparam int RES_W = $bits(result_t);

  frame_cfg_t       cfg;
  cmd_item_t        cmd_in;
  cmd_item_t        cmd_item;
  logic [CMD_W-1:0] cmd_bits;
  logic             cmd_empty;
  logic             cmd_pop;
  result_t          res_item;
  result_t          res_out;
  logic [RES_W-1:0] res_bits;
  logic             res_full;
  logic             res_push;
  logic [CNT_W-1:0] frame_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_HEAD_BYTE:        cfg.head_byte        <= cfg_data;
        CFG_TAIL_FIRST_BYTE:  cfg.tail_first_byte  <= cfg_data;
        CFG_TAIL_SECOND_BYTE: cfg.tail_second_byte <= cfg_data;
        default:              cfg <= cfg;
      endcase
    end
  end

  // Front: classify the incoming item and queue it for the engine.
  always_comb begin
    cmd_in.op   = (operation == 1'b1) ? OP_IDLE : OP_BYTE;
    cmd_in.data = rx_byte;
  end

  ufr_queue #(
    .WIDTH(CMD_W),
    .DEPTH(UFR_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(cmd_in),
    .full   (full),
    .pop    (cmd_pop),
    .rd_data(cmd_bits),
    .empty  (cmd_empty)
  );

  assign cmd_item = cmd_item_t'(cmd_bits);

  ufr_engine #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .CNT_W       (CNT_W)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_empty  (cmd_empty),
    .cmd_item   (cmd_item),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_item   (res_item),
    .frame_count(frame_count)
  );

  ufr_queue #(
    .WIDTH(RES_W),
    .DEPTH(UFR_QUEUE_DEPTH)
  ) u_res_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (res_push),
    .wr_data(res_item),
    .full   (res_full),
    .pop    (pop),
    .rd_data(res_bits),
    .empty  (empty)
  );

  assign res_out        = result_t'(res_bits);
  assign frame_status   = res_out.frame_status;
  assign command        = res_out.command;
  assign payload_length = res_out.payload_length;
  assign frame_crc      = res_out.frame_crc;
  assign computed_crc   = res_out.computed_crc;

  // A verdict must never be pushed into a full result queue, or it is lost.
  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("verdict pushed while the result queue is full");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    frame_count <= CNT_W'(BUFFER_BYTES))
    else $error("frame byte count beyond the buffer size");

  // Closing a frame returns the count to zero on the next cycle.
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    res_push |=> frame_count == '0)
    else $error("frame state not cleared after a verdict");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_item.frame_status == STATUS_TOO_SHORT) |->
      (res_item.command == '0 && res_item.payload_length == '0 &&
       res_item.frame_crc == '0 && res_item.computed_crc == '0))
    else $error("too-short verdict carries non-zero fields");

endmodule
